// ===== hdl/plrf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line fit filter package
// Shared types and constants of the sliding window line fit filter.
// ---------------------------------------------------------------------------
package plrf_pkg;

  localparam int unsigned DW = 64;

  typedef enum logic [2:0] {
    REG_WINDOW_SIZE   = 3'd0,
    REG_TRIGGER_FRAC  = 3'd1,
    REG_REL_ERR_THR   = 3'd2,
    REG_INIT_MAX      = 3'd3,
    REG_AUTO_MAX      = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DROP,
    ST_WRITE,
    ST_CHECK,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_MUL,
    ST_MUL_WAIT,
    ST_FIT,
    ST_FIT_WAIT,
    ST_AVG,
    ST_AVG_WAIT,
    ST_OUT
  } state_e;

endpackage

// ===== hdl/piecewise_linear_regression_filter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sliding window line fit filter
// Least-squares line over the latest samples with tail error check, window
// halving and clamped output, computed on one shared serial arithmetic unit.
// ---------------------------------------------------------------------------
// Each word passes the drop, write and sample count check states, then the sum, multiply, fit
// and average passes before the result is valid; after every halving the sum, multiply and fit
// passes run again from the sample count check. Passthrough words go from the sample count
// check straight to the output. One word is taken at a time; the next can be taken from the
// cycle after the previous result is loaded. Reset empties the window and loads register defaults.
module piecewise_linear_regression_filter
  import plrf_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // filtered_value, avg_abs_error,
                                      // history_length
  output logic        m_axis_tuser    // passthrough
);

  localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned PW = $clog2(WINDOW_MAX);
  localparam int unsigned NW = DW + FRAC_BITS;

  state_e state_q, state_d;

  logic [6:0]  ws_q;
  logic [8:0]  tf_q;
  logic [15:0] thr_q;
  logic        ame_q;
  logic [14:0] cm_q;

  logic [CW-1:0] fill_q;
  logic [PW-1:0] oldest_q;
  logic signed [15:0] smp_q;

  logic signed [DW-1:0] sy_q, sxy_q, sx_q, sxx_q;
  logic signed [DW-1:0] t_q, den_q, base_q, slope_q, num_q;
  logic signed [DW-1:0] limit_q, abs_q, run_q, top_q;
  logic [CW-1:0] k_q, x_q, start_q;
  logic [2:0]    mstep_q;

  logic signed [15:0] res_fv_q;
  logic [23:0]        res_avg_q;
  logic [6:0]         res_hist_q;
  logic               res_pass_q;

  logic        m_valid_q;
  logic [47:0] m_data_q;
  logic        m_user_q;

  logic [CW-1:0] wsz;
  logic [8:0]    tf_eff;
  logic          accept;
  logic          out_free;

  alu_ctrl_t      alu_ctrl;
  logic [NW-1:0]  alu_a;
  logic [DW-1:0]  alu_b;
  logic           alu_done;
  logic [NW-1:0]  alu_res;

  logic           ram_we;
  logic [PW-1:0]  ram_waddr, ram_raddr;
  logic signed [15:0] ram_rdata;

  logic signed [DW-1:0] prod;
  logic signed [DW-1:0] num_mag;
  logic                 num_neg;
  logic signed [DW-1:0] fit_val, err, err_abs, abs_next, run_next, run_abs;
  logic                 trip;
  logic signed [CW+16:0] ky;
  logic [2*CW-1:0]       kk;
  logic [CW+8:0]         tail_prod;
  logic [CW-1:0]         tail, xm1;
  logic [30:0]           lim_prod;
  logic signed [DW-1:0]  cap, topc, fv_full;

  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] p, logic [CW-1:0] d);
    logic [CW:0] s;
    s = (CW+1)'(p) + (CW+1)'(d);
    if (s >= (CW+1)'(WINDOW_MAX)) begin
      s = s - (CW+1)'(WINDOW_MAX);
    end
    return PW'(s);
  endfunction

  always_comb begin
    if (ws_q == 7'd0) begin
      wsz = CW'(1);
    end else if (32'(ws_q) > WINDOW_MAX) begin
      wsz = CW'(WINDOW_MAX);
    end else begin
      wsz = CW'(ws_q);
    end
    tf_eff = (tf_q > 9'd256) ? 9'd256 : tf_q;
  end

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // Combinational datapath values
  always_comb begin
    prod      = signed'(alu_res[DW-1:0]);
    num_neg   = num_q[DW-1];
    num_mag   = num_neg ? -num_q : num_q;
    fit_val   = num_neg ? '0 : signed'(alu_res[DW-1:0]);
    err       = fit_val - (DW'(ram_rdata) <<< FRAC_BITS);
    err_abs   = err[DW-1] ? -err : err;
    abs_next  = abs_q + err_abs;
    run_next  = (x_q < fill_q - CW'(1)) ? run_q + err : run_q;
    run_abs   = run_next[DW-1] ? -run_next : run_next;
    trip      = (x_q >= start_q) && (run_abs > limit_q);
    ky        = $signed({1'b0, k_q}) * ram_rdata;
    kk        = k_q * k_q;
    tail_prod = fill_q * (9'd256 - tf_eff);
    tail      = CW'(tail_prod >> 8);
    xm1       = fill_q - CW'(2);
    lim_prod  = cm_q * thr_q;
    cap       = DW'(cm_q) <<< FRAC_BITS;
    topc      = (top_q > cap) ? cap : top_q;
    fv_full   = (topc + (DW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (accept) state_d = ST_DROP;
      ST_DROP:     state_d = ST_WRITE;
      ST_WRITE:    state_d = ST_CHECK;
      ST_CHECK:    state_d = (fill_q < CW'(3)) ? ST_OUT : ST_SUM_RD;
      ST_SUM_RD:   state_d = ST_SUM_ACC;
      ST_SUM_ACC:  state_d = (k_q == fill_q - CW'(1)) ? ST_MUL : ST_SUM_RD;
      ST_MUL:      state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: if (alu_done) state_d = (mstep_q == 3'd6) ? ST_FIT : ST_MUL;
      ST_FIT:      state_d = ST_FIT_WAIT;
      ST_FIT_WAIT: begin
        if (alu_done) begin
          if (trip) begin
            state_d = ST_CHECK;
          end else if (x_q == '0) begin
            state_d = ST_AVG;
          end else begin
            state_d = ST_FIT;
          end
        end
      end
      ST_AVG:      state_d = ST_AVG_WAIT;
      ST_AVG_WAIT: if (alu_done) state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready  = (state_q == ST_IDLE);
    ram_we         = (state_q == ST_WRITE);
    ram_waddr      = wrap_add(oldest_q, fill_q);
    ram_raddr      = (state_q == ST_FIT || state_q == ST_FIT_WAIT) ?
                     wrap_add(oldest_q, x_q) : wrap_add(oldest_q, k_q);
    alu_ctrl.start = 1'b0;
    alu_ctrl.op    = ALU_MUL;
    alu_a          = '0;
    alu_b          = '0;
    unique case (state_q)
      ST_MUL: begin
        alu_ctrl.start = 1'b1;
        unique case (mstep_q)
          3'd0: begin alu_a = NW'(fill_q);   alu_b = sxx_q;   end
          3'd1: begin alu_a = NW'(sx_q);     alu_b = sx_q;    end
          3'd2: begin alu_a = NW'(sy_q);     alu_b = sxx_q;   end
          3'd3: begin alu_a = NW'(sx_q);     alu_b = sxy_q;   end
          3'd4: begin alu_a = NW'(fill_q);   alu_b = sxy_q;   end
          3'd5: begin alu_a = NW'(sx_q);     alu_b = sy_q;    end
          default: begin
            alu_a = NW'(fill_q - CW'(1));
            alu_b = slope_q;
          end
        endcase
      end
      ST_FIT: begin
        alu_ctrl.start = 1'b1;
        alu_ctrl.op    = ALU_DIV;
        alu_a = (NW'(unsigned'(num_mag)) << FRAC_BITS) + NW'(unsigned'(den_q) >> 1);
        alu_b = den_q;
      end
      ST_AVG: begin
        alu_ctrl.start = 1'b1;
        alu_ctrl.op    = ALU_DIV;
        alu_a = NW'(unsigned'(abs_q));
        alu_b = DW'(fill_q) << (FRAC_BITS - 8);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ws_q      <= 7'd64;
      tf_q      <= 9'd64;
      thr_q     <= 16'd256;
      ame_q     <= 1'b1;
      cm_q      <= 15'd32767;
      fill_q    <= '0;
      oldest_q  <= '0;
      mstep_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && ame_q && $signed(s_axis_tdata) > $signed({1'b0, cm_q})) begin
            cm_q <= s_axis_tdata[14:0];
          end
        end
        ST_DROP: begin
          if (fill_q >= wsz) begin
            oldest_q <= wrap_add(oldest_q, fill_q - wsz + CW'(1));
            fill_q   <= wsz - CW'(1);
          end
        end
        ST_WRITE:    fill_q <= fill_q + CW'(1);
        ST_SUM_ACC:  if (k_q == fill_q - CW'(1)) mstep_q <= '0;
        ST_MUL_WAIT: if (alu_done) mstep_q <= mstep_q + 3'd1;
        ST_FIT_WAIT: begin
          if (alu_done && trip) begin
            oldest_q <= wrap_add(oldest_q, fill_q >> 1);
            fill_q   <= fill_q - (fill_q >> 1);
          end
        end
        default: ;
      endcase
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WINDOW_SIZE:  ws_q  <= cfg_wdata_i[6:0];
          REG_TRIGGER_FRAC: tf_q  <= cfg_wdata_i[8:0];
          REG_REL_ERR_THR:  thr_q <= cfg_wdata_i;
          REG_INIT_MAX:     cm_q  <= cfg_wdata_i[14:0];
          REG_AUTO_MAX:     ame_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (accept) smp_q <= s_axis_tdata;
      ST_CHECK: begin
        sy_q  <= '0;
        sxy_q <= '0;
        sx_q  <= '0;
        sxx_q <= '0;
        k_q   <= '0;
        start_q <= (xm1 < tail) ? xm1 : tail;
        res_fv_q   <= smp_q;
        res_avg_q  <= '0;
        res_hist_q <= 7'(fill_q);
        res_pass_q <= 1'b1;
      end
      ST_SUM_ACC: begin
        sy_q  <= sy_q + DW'(ram_rdata);
        sxy_q <= sxy_q + DW'(ky);
        sx_q  <= sx_q + DW'(k_q);
        sxx_q <= sxx_q + DW'(kk);
        k_q   <= k_q + CW'(1);
      end
      ST_MUL_WAIT: begin
        if (alu_done) begin
          unique case (mstep_q)
            3'd0, 3'd2, 3'd4: t_q <= prod;
            3'd1: den_q   <= t_q - prod;
            3'd3: base_q  <= t_q - prod;
            3'd5: slope_q <= t_q - prod;
            default: begin
              num_q   <= base_q + prod;
              x_q     <= fill_q - CW'(1);
              abs_q   <= '0;
              run_q   <= '0;
              limit_q <= DW'(lim_prod) <<< (FRAC_BITS - 8);
            end
          endcase
        end
      end
      ST_FIT_WAIT: begin
        if (alu_done) begin
          abs_q <= abs_next;
          run_q <= run_next;
          if (x_q == fill_q - CW'(1)) begin
            top_q <= fit_val;
          end
          x_q   <= x_q - CW'(1);
          num_q <= num_q - slope_q;
        end
      end
      ST_AVG_WAIT: begin
        if (alu_done) begin
          res_avg_q  <= (alu_res > NW'(24'hFFFFFF)) ? 24'hFFFFFF : alu_res[23:0];
          res_fv_q   <= fv_full[15:0];
          res_hist_q <= 7'(fill_q);
          res_pass_q <= 1'b0;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          m_data_q <= {1'b0, res_hist_q, res_avg_q, res_fv_q};
          m_user_q <= res_pass_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  plrf_ram #(
    .DEPTH (WINDOW_MAX),
    .AW    (PW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (smp_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  plrf_alu #(
    .NW (NW)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (alu_ctrl),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

endmodule

// ===== hdl/plrf_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sample window memory
// Single write port and one registered read port holding the sample ring.
// ---------------------------------------------------------------------------
module plrf_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic signed [15:0] wdata_i,
  input  logic [AW-1:0]      raddr_i,
  output logic signed [15:0] rdata_o
);

  logic signed [15:0] mem_q [DEPTH];
  logic signed [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/plrf_alu.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Shared multiply and divide unit
// Bit-serial shift-add multiplier and restoring divider, one bit a cycle.
// ---------------------------------------------------------------------------
module plrf_alu
  import plrf_pkg::*;
#(
  parameter int unsigned NW = 80
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  alu_ctrl_t     ctrl_i,
  input  logic [NW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  output logic          done_o,
  output logic [NW-1:0] res_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  alu_op_e         op_q;
  logic [NW-1:0]   acc_q;
  logic [NW-1:0]   opa_q;
  logic [DW-1:0]   opb_q;
  logic [DW:0]     trial;
  logic            fits;

  assign trial = {acc_q[DW-1:0], opa_q[NW-1]};
  assign fits  = trial >= {1'b0, opb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_MUL;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        op_q   <= ctrl_i.op;
        cnt_q  <= (ctrl_i.op == ALU_MUL) ? CNTW'(DW) : CNTW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q <= '0;
      opa_q <= a_i;
      opb_q <= b_i;
    end else if (busy_q) begin
      if (op_q == ALU_MUL) begin
        if (opb_q[0]) begin
          acc_q <= acc_q + opa_q;
        end
        opa_q <= {opa_q[NW-2:0], 1'b0};
        opb_q <= {1'b0, opb_q[DW-1:1]};
      end else begin
        acc_q <= fits ? NW'(trial - {1'b0, opb_q}) : NW'(trial);
        opa_q <= {opa_q[NW-2:0], fits};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == ALU_MUL) ? acc_q : opa_q;

endmodule
